// ----- hw/rtl/ucf_pkg.sv -----
// Shared types and constants for the UART command-line framer.
// Depends on nothing; imported by every framer module but the queue, and by the testbench.
`timescale 1ns / 1ps

package ucf_pkg;

    localparam int LINE_DEPTH_DEF = 32;

    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    localparam logic KIND_PASS = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [1:0] {
        MD_PASS    = 2'd0,
        MD_CMD     = 2'd1,
        MD_WAIT_LF = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SEND = 2'd2
    } back_state_t;

endpackage

// ----- hw/rtl/ucf_front.sv -----
// Front end of the framer: accepts received words, tracks the line mode,
// writes the line store and queues forward or emit-line commands. Uses ucf_pkg.
`timescale 1ns / 1ps

module ucf_front
    import ucf_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    parameter int CW         = $clog2(LINE_DEPTH + 1),
    parameter int AW         = $clog2(LINE_DEPTH),
    parameter int QW         = 1 + 8 + CW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          q_push,
    output logic [QW-1:0] q_entry,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    input  logic          line_done
);

    mode_t         mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic          emitted_reg, emitted_next;
    logic          busy_reg, busy_next;
    logic          accept;
    logic          push_line;
    logic          emit_ok;

    assign in_stall = q_full || busy_reg;
    assign accept   = in_valid && !in_stall;
    assign emit_ok  = (count_reg != '0) && !emitted_reg;

    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MD_PASS:
            begin
                if (accept && rx_byte == CH_PLUS)
                    mode_next = MD_CMD;
            end
            MD_CMD:
            begin
                if (accept && rx_byte == CH_CR)
                    mode_next = MD_WAIT_LF;
                else if (accept && rx_byte == CH_LF)
                    mode_next = MD_PASS;
            end
            MD_WAIT_LF:
            begin
                if (accept && rx_byte == CH_LF)
                    mode_next = MD_PASS;
            end
            default:
            begin
                if (accept)
                    mode_next = MD_PASS;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        emitted_next = emitted_reg;
        q_push       = 1'b0;
        push_line    = 1'b0;
        wr_en        = 1'b0;
        unique case (mode_reg)
            MD_PASS:
            begin
                if (accept)
                begin
                    if (rx_byte == CH_PLUS)
                    begin
                        count_next   = '0;
                        emitted_next = 1'b0;
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
            end
            MD_CMD:
            begin
                if (accept && rx_byte != CH_CR)
                begin
                    if (rx_byte == CH_LF)
                    begin
                        if (emit_ok)
                        begin
                            q_push       = 1'b1;
                            push_line    = 1'b1;
                            emitted_next = 1'b1;
                        end
                    end
                    else if (count_reg < CW'(LINE_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            MD_WAIT_LF:
            begin
                if (accept && emit_ok)
                begin
                    q_push       = 1'b1;
                    push_line    = 1'b1;
                    emitted_next = 1'b1;
                end
            end
            default:
            begin
                if (accept)
                begin
                    count_next   = '0;
                    emitted_next = 1'b1;
                end
            end
        endcase
    end

    // hold input off from a queued line until its last word has left the store
    always_comb
    begin
        busy_next = busy_reg;
        if (push_line)
            busy_next = 1'b1;
        else if (line_done)
            busy_next = 1'b0;
    end

    assign q_entry = {push_line, rx_byte, count_reg};
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MD_PASS;
            count_reg   <= '0;
            emitted_reg <= 1'b1;
            busy_reg    <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
            busy_reg    <= busy_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LINE_DEPTH))
        else $error("line count beyond store depth");

    a_line_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push_line |-> (count_reg != '0) && !emitted_reg)
        else $error("empty or repeated line queued");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (mode_reg == MD_CMD) && !busy_reg && !line_done)
        else $error("store written while a line drains");

endmodule

// ----- hw/rtl/ucf_queue.sv -----
// Two-entry command queue between the framer front and back ends.
// Depends on nothing beyond its width parameter.
`timescale 1ns / 1ps

module ucf_queue
#(
    parameter int QW = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [QW-1:0] push_entry,
    input  logic          pop,
    output logic [QW-1:0] head,
    output logic          full,
    output logic          empty
);

    logic [QW-1:0] slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill out of range");

endmodule

// ----- hw/rtl/ucf_back.sv -----
// Back end of the framer: holds the line store, drains queued commands and
// drives the output register. Uses ucf_pkg.
`timescale 1ns / 1ps

module ucf_back
    import ucf_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    parameter int CW         = $clog2(LINE_DEPTH + 1),
    parameter int AW         = $clog2(LINE_DEPTH),
    parameter int QW         = 1 + 8 + CW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  logic [QW-1:0] q_head,
    output logic          q_pop,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic          line_done,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          kind,
    output logic [7:0]    data,
    output logic          last
);

    logic [7:0]    store_mem [LINE_DEPTH];
    logic [7:0]    rd_data_reg;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] len_reg, len_next;
    logic          out_valid_reg, out_valid_next;
    logic          kind_reg, kind_next;
    logic [7:0]    data_reg, data_next;
    logic          last_reg, last_next;

    logic          head_line;
    logic [7:0]    head_byte;
    logic [CW-1:0] head_count;
    logic          out_free;
    logic          final_word;
    logic          load;

    assign head_line  = q_head[QW-1];
    assign head_byte  = q_head[CW +: 8];
    assign head_count = q_head[CW-1:0];
    assign out_free   = !out_valid_reg || !out_stall;
    assign final_word = (CW'(idx_reg) + CW'(1)) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && head_line)
                    state_next = BK_READ;
            end
            BK_READ:
            begin
                state_next = BK_SEND;
            end
            BK_SEND:
            begin
                if (out_free)
                    state_next = final_word ? BK_IDLE : BK_READ;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load      = 1'b0;
        line_done = 1'b0;
        idx_next  = idx_reg;
        len_next  = len_reg;
        kind_next = kind_reg;
        data_next = data_reg;
        last_next = last_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head_line)
                    begin
                        q_pop    = 1'b1;
                        idx_next = '0;
                        len_next = head_count;
                    end
                    else if (out_free)
                    begin
                        q_pop     = 1'b1;
                        load      = 1'b1;
                        kind_next = KIND_PASS;
                        data_next = head_byte;
                        last_next = 1'b1;
                    end
                end
            end
            BK_READ:
            begin
            end
            BK_SEND:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    kind_next = KIND_LINE;
                    data_next = rd_data_reg;
                    last_next = final_word;
                    line_done = final_word;
                    idx_next  = idx_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        if (state_reg == BK_READ)
            rd_data_reg <= store_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_PASS) |-> last_reg)
        else $error("pass-through word without last flag");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> (len_reg != '0) && (CW'(idx_reg) < len_reg))
        else $error("line read beyond stored length");

    a_no_pop_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !q_pop)
        else $error("queue popped while a line drains");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |=> out_valid_reg && last_reg && (kind_reg == KIND_LINE))
        else $error("line end without final word");

endmodule

// ----- hw/rtl/uart_command_line_framer.sv -----
// UART command-line framer top level: front end, two-entry queue, back end.
// Pass-through word: queue slot, then output register; one word per cycle unless
// stalled. Line end: each run word is read, then sent; input stalls from the
// line-end word until the last run word is in the output register (store port).
// Reset (rst_n, async low): pass-through mode, empty line, queue and output empty.
`timescale 1ns / 1ps

module uart_command_line_framer
    import ucf_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data,
    output logic       last
);

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int QW = 1 + 8 + CW;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_head;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          line_done;

    ucf_front #(
        .LINE_DEPTH (LINE_DEPTH),
        .CW         (CW),
        .AW         (AW),
        .QW         (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .line_done (line_done)
    );

    ucf_queue #(
        .QW (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    ucf_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .CW         (CW),
        .AW         (AW),
        .QW         (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .line_done (line_done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule

// ----- tb/ucf_line_checker.sv -----
// Checker for the UART command-line framer: watches both channels, predicts each word.
// Compares output words in order against the prediction.
// Depends on ucf_pkg for the mode encoding, the character codes and the word kinds.
`timescale 1ns / 1ps

module ucf_line_checker
    import ucf_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       kind,
    input  logic [7:0] data,
    input  logic       last,
    output int         fails,
    output int         owed,
    output int         fwd_words,
    output int         line_words,
    output int         lines_seen
);

    typedef struct packed {
        logic       k;
        logic [7:0] d;
        logic       l;
    } framed_word_t;

    framed_word_t owed_words[$];

    mode_t      mode;
    logic [7:0] line_buf [LINE_DEPTH];
    int         line_len;
    logic       line_done;

    // emit the stored line once, last flag on its final byte
    task automatic drain_line();
        framed_word_t w;
        if (line_len != 0 && !line_done)
        begin
            for (int i = 0; i < line_len; i++)
            begin
                w.k = KIND_LINE;
                w.d = line_buf[i];
                w.l = (i == line_len - 1);
                owed_words.push_back(w);
            end
            line_done = 1'b1;
        end
    endtask

    task automatic frame_rx_byte(input logic [7:0] b);
        framed_word_t w;
        case (mode)
            MD_PASS:
                if (b == CH_PLUS)
                begin
                    mode      = MD_CMD;
                    line_len  = 0;
                    line_done = 1'b0;
                end
                else
                begin
                    w.k = KIND_PASS;
                    w.d = b;
                    w.l = 1'b1;
                    owed_words.push_back(w);
                end
            MD_CMD:
                if (b == CH_CR)
                    mode = MD_WAIT_LF;
                else if (b == CH_LF)
                begin
                    mode = MD_PASS;
                    drain_line();
                end
                else if (line_len < LINE_DEPTH)
                begin
                    line_buf[line_len] = b;
                    line_len++;
                end
                // full store: drop the byte
            MD_WAIT_LF:
            begin
                if (b == CH_LF)
                    mode = MD_PASS;
                drain_line();
            end
            default:
            begin
                mode      = MD_PASS;
                line_len  = 0;
                line_done = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        framed_word_t w;
        if (!rst_n)
        begin
            mode      = MD_PASS;
            line_len  = 0;
            line_done = 1'b1;
            owed_words.delete();
            fails      = 0;
            owed       = 0;
            fwd_words  = 0;
            line_words = 0;
            lines_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                frame_rx_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("unexpected word: kind %0d data %02h last %0d", kind, data, last);
                    fails++;
                end
                else
                begin
                    w = owed_words.pop_front();
                    if (kind !== w.k)
                    begin
                        $error("kind: expected %0d, got %0d", w.k, kind);
                        fails++;
                    end
                    if (data !== w.d)
                    begin
                        $error("data: expected %02h, got %02h", w.d, data);
                        fails++;
                    end
                    if (last !== w.l)
                    begin
                        $error("last: expected %0d, got %0d", w.l, last);
                        fails++;
                    end
                end
                if (kind === KIND_LINE)
                begin
                    line_words++;
                    if (last === 1'b1)
                        lines_seen++;
                end
                else
                    fwd_words++;
            end
            owed = owed_words.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the framer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
// Depends on ucf_pkg, uart_command_line_framer and ucf_line_checker.
`timescale 1ns / 1ps

module tb_top
    import ucf_pkg::*;
();

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [7:0] data;
    logic       last;

    int fails;
    int owed;
    int fwd_words;
    int line_words;
    int lines_seen;

    logic quiet;
    logic hold_req;
    int   hold_left;
    int   bytes_sent;
    int   rand_sent;

    uart_command_line_framer #(.LINE_DEPTH(LINE_DEPTH_DEF)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .data(data), .last(last)
    );

    ucf_line_checker #(.LINE_DEPTH(LINE_DEPTH_DEF)) chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .data(data), .last(last),
        .fails(fails), .owed(owed), .fwd_words(fwd_words),
        .line_words(line_words), .lines_seen(lines_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 19);
        end
    end

    // offer one word and hold it until accepted
    task automatic put_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic put_line();
        int len;
        int tail;
        if ($urandom_range(9) < 8)
            len = $urandom_range(0, 8);
        else
            len = $urandom_range(LINE_DEPTH_DEF - 2, LINE_DEPTH_DEF + 2);
        put_byte(CH_PLUS);
        repeat (len) put_byte(body_byte());
        tail = $urandom_range(9);
        if (tail >= 5)
        begin
            put_byte(CH_CR);
            // stray bytes after CR: only the first one ends the line
            if (tail >= 8)
                repeat ($urandom_range(1, 3)) put_byte(body_byte());
        end
        put_byte(CH_LF);
        rand_sent += len + 2;
    endtask

    initial
    begin
        logic [7:0] directed[$];
        logic [7:0] b;
        logic       pressed;

        directed = {8'h00, 8'hFF, CH_CR, CH_LF,
                    CH_PLUS, 8'h41, 8'h42, CH_LF,
                    CH_PLUS, CH_LF,
                    CH_PLUS, 8'h00, 8'hFF, CH_CR, 8'h78, CH_LF,
                    CH_PLUS, 8'h71, CH_CR, CH_CR, CH_LF,
                    CH_PLUS, CH_CR, 8'h55, CH_LF,
                    CH_PLUS, CH_PLUS, 8'h7A, CH_LF};
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        rst_n      = 1'b0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        bytes_sent = 0;
        rand_sent  = 0;
        pressed    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i]) put_byte(directed[i]);

        // overfill the store so that trailing bytes are dropped
        put_byte(CH_PLUS);
        repeat (LINE_DEPTH_DEF + 3) put_byte(body_byte());
        put_byte(CH_LF);

        while (rand_sent < 40)
        begin
            quiet = (rand_sent >= 15 && rand_sent < 35);
            if (!pressed && rand_sent >= 5)
            begin
                // make sure of pass-through mode, then flood while the receiver holds
                put_byte(CH_LF);
                hold_req = 1'b1;
                repeat (12)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_PLUS);
                    put_byte(b);
                end
                rand_sent += 13;
                pressed = 1'b1;
            end
            else if ($urandom_range(9) < 6)
                put_line();
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    put_byte(8'($urandom_range(0, 255)));
                    rand_sent++;
                end
            end
        end
        put_byte(CH_LF);
        in_valid <= 1'b0;

        while (owed != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("tb: %0d input words sent; %0d forwarded words and %0d line words seen",
                 bytes_sent, fwd_words, line_words);
        $display("tb: %0d command lines completed, including a full store and a long hold-off",
                 lines_seen);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
